// ----- hdl/dft_pkg.sv -----
// ----------------------------------------------------------------------------
// dft_pkg
// Types and constants shared by the delimited field tokenizer.
// ----------------------------------------------------------------------------
package dft_pkg;

    localparam logic [2:0] KIND_BYTE       = 3'd0;
    localparam logic [2:0] KIND_FIELD_END  = 3'd1;
    localparam logic [2:0] KIND_BAD_QUOTE  = 3'd2;
    localparam logic [2:0] KIND_BAD_ESCAPE = 3'd3;
    localparam logic [2:0] KIND_RECORD_END = 3'd4;

    localparam logic [7:0] BACKSLASH_BYTE = 8'd92;

    localparam logic [2:0] CFG_DELIM_CHAR     = 3'd0;
    localparam logic [2:0] CFG_QUOTE_CHAR     = 3'd1;
    localparam logic [2:0] CFG_COLLAPSE       = 3'd2;
    localparam logic [2:0] CFG_BACKSLASH      = 3'd3;
    localparam logic [2:0] CFG_DOUBLED_QUOTE  = 3'd4;
    localparam logic [2:0] CFG_STRICT         = 3'd5;

    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    // result queue entries; pointers wrap naturally, so keep a power of two
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] delim_char;
        logic [7:0] quote_char;
        logic       collapse_delims;
        logic       backslash_escapes;
        logic       doubled_quote_escapes;
        logic       strict_mode;
    } t_cfg;

    typedef struct packed {
        logic inside_quotes;
        logic field_nonempty;
        logic after_delimiter;
        logic skipping_delimiters;
        logic quote_waiting;
        logic escape_waiting;
        logic record_halted;
    } t_state;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } t_result;

endpackage

// ----- hdl/dft_if.sv -----
// ----------------------------------------------------------------------------
// dft_in_if / dft_out_if
// Valid/ready channels for record bytes and tokenizer results.
// ----------------------------------------------------------------------------
interface dft_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] in_byte;

    modport source (output valid, output cmd, output in_byte, input ready);
    modport sink   (input valid, input cmd, input in_byte, output ready);
endinterface

interface dft_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// ----- hdl/delimited_field_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// delimited_field_tokenizer_unit
// Splits records of bytes into fields, quote and escape aware.
// ----------------------------------------------------------------------------
// Output: first result of a byte is offered in the cycle after its transfer
//   when the result queue is empty.
// Throughput: 1 byte per cycle while the queue has room for two results; a
//   byte giving two results is absorbed by the 4-entry result queue; a long
//   run of such bytes stalls input until results drain from the queue.
// Reset: synchronous, active low; clears record state and the queue and
//   returns the registers to their defaults.
// ----------------------------------------------------------------------------
module delimited_field_tokenizer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dft_in_if.sink     i_in,
    dft_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    dft_pkg::t_cfg    r_cfg;
    dft_pkg::t_state  r_state;
    dft_pkg::t_state  n_state;
    dft_pkg::t_result res0;
    dft_pkg::t_result res1;
    dft_pkg::t_result head;
    logic [1:0]       count;
    logic             room;
    logic             take;

    assign take       = i_in.valid && room;
    assign i_in.ready = room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{delim_char: dft_pkg::DELIM_RESET, quote_char: dft_pkg::QUOTE_RESET,
                       default: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dft_pkg::CFG_DELIM_CHAR:    r_cfg.delim_char            <= i_cfg_data;
                dft_pkg::CFG_QUOTE_CHAR:    r_cfg.quote_char            <= i_cfg_data;
                dft_pkg::CFG_COLLAPSE:      r_cfg.collapse_delims       <= i_cfg_data[0];
                dft_pkg::CFG_BACKSLASH:     r_cfg.backslash_escapes     <= i_cfg_data[0];
                dft_pkg::CFG_DOUBLED_QUOTE: r_cfg.doubled_quote_escapes <= i_cfg_data[0];
                dft_pkg::CFG_STRICT:        r_cfg.strict_mode           <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    dft_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_cmd   (i_in.cmd),
        .i_byte  (i_in.in_byte),
        .o_state (n_state),
        .o_count (count),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (take) begin
            r_state <= n_state;
        end
    end

    dft_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (take ? count : 2'd0),
        .i_res0       (res0),
        .i_res1       (res1),
        .o_room       (room),
        .o_valid      (o_out.valid),
        .i_pop        (o_out.ready),
        .o_res        (head)
    );

    assign o_out.kind     = head.kind;
    assign o_out.out_byte = head.out_byte;
    assign o_out.last     = head.last;

endmodule

// ----- hdl/dft_step.sv -----
// ----------------------------------------------------------------------------
// dft_step
// Per-byte decode: next tokenizer state and up to two results.
// ----------------------------------------------------------------------------
module dft_step (
    input  dft_pkg::t_cfg    i_cfg,
    input  dft_pkg::t_state  i_state,
    input  logic             i_cmd,
    input  logic [7:0]       i_byte,
    output dft_pkg::t_state  o_state,
    output logic [1:0]       o_count,
    output dft_pkg::t_result o_res0,
    output dft_pkg::t_result o_res1
);

    dft_pkg::t_state s;
    logic [1:0]      n;
    logic [2:0]      k0;
    logic [2:0]      k1;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic            consumed;
    logic            quoted;

    always_comb begin
        s        = i_state;
        n        = 2'd0;
        k0       = dft_pkg::KIND_BYTE;
        k1       = dft_pkg::KIND_BYTE;
        b0       = 8'd0;
        b1       = 8'd0;
        consumed = 1'b0;
        quoted   = i_state.inside_quotes ^ i_state.quote_waiting;

        if (i_cmd) begin
            s = '0;
            n = 2'd2;
            k1 = dft_pkg::KIND_RECORD_END;
            if (i_state.escape_waiting && i_cfg.strict_mode) begin
                k0 = dft_pkg::KIND_BAD_ESCAPE;
            end else if (i_cfg.strict_mode && quoted) begin
                k0 = dft_pkg::KIND_BAD_QUOTE;
            end else if (i_state.after_delimiter || i_state.field_nonempty) begin
                k0 = dft_pkg::KIND_FIELD_END;
            end else begin
                n  = 2'd1;
                k0 = dft_pkg::KIND_RECORD_END;
            end
        end else if (i_state.record_halted) begin
            n = 2'd0;
        end else if (i_state.escape_waiting) begin
            s.escape_waiting  = 1'b0;
            s.after_delimiter = 1'b0;
            s.field_nonempty  = 1'b1;
            n  = 2'd2;
            b0 = dft_pkg::BACKSLASH_BYTE;
            b1 = i_byte;
        end else begin
            if (i_state.quote_waiting) begin
                s.quote_waiting = 1'b0;
                if (i_byte == i_cfg.quote_char) begin
                    n = 2'd1;
                    b0 = i_byte;
                    s.field_nonempty  = 1'b1;
                    s.after_delimiter = 1'b0;
                    consumed = 1'b1;
                end else begin
                    s.inside_quotes = ~s.inside_quotes;
                end
            end else if (i_state.skipping_delimiters) begin
                if (i_byte == i_cfg.delim_char) begin
                    consumed = 1'b1;
                end else begin
                    s.skipping_delimiters = 1'b0;
                end
            end

            if (!consumed) begin
                s.after_delimiter = 1'b0;
                if (i_byte == 8'd0) begin
                    s.record_halted = 1'b1;
                end else if (!s.inside_quotes && i_byte == i_cfg.delim_char) begin
                    n  = 2'd1;
                    k0 = dft_pkg::KIND_FIELD_END;
                    s.field_nonempty      = 1'b0;
                    s.after_delimiter     = 1'b1;
                    s.skipping_delimiters = i_cfg.collapse_delims;
                end else if (i_byte == i_cfg.quote_char) begin
                    if (i_cfg.doubled_quote_escapes) begin
                        s.quote_waiting = 1'b1;
                    end else begin
                        s.inside_quotes = ~s.inside_quotes;
                    end
                end else if (i_cfg.backslash_escapes && i_byte == dft_pkg::BACKSLASH_BYTE) begin
                    s.escape_waiting = 1'b1;
                end else begin
                    n  = 2'd1;
                    b0 = i_byte;
                    s.field_nonempty = 1'b1;
                end
            end
        end
    end

    assign o_state = s;
    assign o_count = n;
    assign o_res0  = '{kind: k0, out_byte: b0, last: (n == 2'd1)};
    assign o_res1  = '{kind: k1, out_byte: b1, last: 1'b1};

endmodule

// ----- hdl/dft_queue.sv -----
// ----------------------------------------------------------------------------
// dft_queue
// Result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module dft_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_count,
    input  dft_pkg::t_result i_res0,
    input  dft_pkg::t_result i_res1,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_pop,
    output dft_pkg::t_result o_res
);

    localparam int DEPTH = dft_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    dft_pkg::t_result r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    wr_next;
    logic             pop;

    assign wr_next = r_wr + PW'(1);
    assign pop     = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_next] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PW'(i_push_count);
            r_rd  <= r_rd + PW'(pop);
            r_cnt <= r_cnt + CW'(i_push_count) - CW'(pop);
        end
    end

    assign o_room  = (r_cnt <= CW'(DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];

endmodule

// ----- hdl/dft_checker.sv -----
// ----------------------------------------------------------------------------
// dft_checker
// Port-level checks on the tokenizer result channel.
// ----------------------------------------------------------------------------
module dft_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_kind,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != dft_pkg::KIND_BYTE |-> i_out_byte == 8'd0)
        else $error("nonzero byte on a mark");

    a_rec_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == dft_pkg::KIND_RECORD_END |-> i_out_last)
        else $error("record end not last");

    a_err_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_out_kind == dft_pkg::KIND_BAD_QUOTE ||
        i_out_kind == dft_pkg::KIND_BAD_ESCAPE) |=> i_out_valid &&
        i_out_kind == dft_pkg::KIND_RECORD_END)
        else $error("error mark not followed by record end");

endmodule

bind delimited_field_tokenizer_unit dft_checker u_dft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last)
);

// ----- bench/dft_token_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dft_token_checker
// Watches the byte and result channels of the field tokenizer, tracks the
// register writes, predicts the results of every byte transfer and compares
// each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module dft_token_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dft_in_if          i_in,
    dft_out_if         i_out,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output int         o_mismatches,
    output int         o_pending,
    output int         o_checked
);

    dft_pkg::t_cfg    cfg;
    dft_pkg::t_state  st;
    dft_pkg::t_result expected_tokens[$];
    dft_pkg::t_result item_tokens[$];
    int               mismatches;
    int               checked;

    task automatic emit(input logic [2:0] kind, input logic [7:0] b);
        dft_pkg::t_result r;
        r.kind     = kind;
        r.out_byte = b;
        r.last     = 1'b0;
        item_tokens = {item_tokens, r};
    endtask

    task automatic take_byte(input logic [7:0] b);
        st.after_delimiter = 1'b0;
        if (b == 8'd0) begin
            st.record_halted = 1'b1;
        end else if (!st.inside_quotes && b == cfg.delim_char) begin
            emit(dft_pkg::KIND_FIELD_END, 8'd0);
            st.field_nonempty      = 1'b0;
            st.after_delimiter     = 1'b1;
            st.skipping_delimiters = cfg.collapse_delims;
        end else if (b == cfg.quote_char) begin
            if (cfg.doubled_quote_escapes) begin
                st.quote_waiting = 1'b1;
            end else begin
                st.inside_quotes = !st.inside_quotes;
            end
        end else if (cfg.backslash_escapes && b == dft_pkg::BACKSLASH_BYTE) begin
            st.escape_waiting = 1'b1;
        end else begin
            emit(dft_pkg::KIND_BYTE, b);
            st.field_nonempty = 1'b1;
        end
    endtask

    task automatic close_record();
        if (st.quote_waiting) begin
            st.quote_waiting = 1'b0;
            st.inside_quotes = !st.inside_quotes;
        end
        if (st.escape_waiting && cfg.strict_mode) begin
            emit(dft_pkg::KIND_BAD_ESCAPE, 8'd0);
        end else if (cfg.strict_mode && st.inside_quotes) begin
            emit(dft_pkg::KIND_BAD_QUOTE, 8'd0);
        end else if (st.after_delimiter || st.field_nonempty) begin
            emit(dft_pkg::KIND_FIELD_END, 8'd0);
        end
        emit(dft_pkg::KIND_RECORD_END, 8'd0);
        st = '0;
    endtask

    task automatic tokenize_item(input logic cmd, input logic [7:0] b);
        logic consumed;
        consumed = 1'b0;
        item_tokens.delete();
        if (cmd) begin
            close_record();
        end else if (st.record_halted) begin
            consumed = 1'b1;
        end else if (st.escape_waiting) begin
            st.escape_waiting  = 1'b0;
            st.after_delimiter = 1'b0;
            emit(dft_pkg::KIND_BYTE, dft_pkg::BACKSLASH_BYTE);
            emit(dft_pkg::KIND_BYTE, b);
            st.field_nonempty = 1'b1;
        end else begin
            if (st.quote_waiting) begin
                st.quote_waiting = 1'b0;
                if (b == cfg.quote_char) begin
                    emit(dft_pkg::KIND_BYTE, b);
                    st.field_nonempty  = 1'b1;
                    st.after_delimiter = 1'b0;
                    consumed = 1'b1;
                end else begin
                    st.inside_quotes = !st.inside_quotes;
                end
            end else if (st.skipping_delimiters) begin
                if (b == cfg.delim_char) begin
                    consumed = 1'b1;
                end else begin
                    st.skipping_delimiters = 1'b0;
                end
            end
            if (!consumed) begin
                take_byte(b);
            end
        end
        if (item_tokens.size() > 0) begin
            item_tokens[item_tokens.size() - 1].last = 1'b1;
        end
        expected_tokens = {expected_tokens, item_tokens};
    endtask

    always @(posedge i_clk) begin
        dft_pkg::t_result want;
        if (!i_rst_n) begin
            cfg.delim_char            = dft_pkg::DELIM_RESET;
            cfg.quote_char            = dft_pkg::QUOTE_RESET;
            cfg.collapse_delims       = 1'b0;
            cfg.backslash_escapes     = 1'b0;
            cfg.doubled_quote_escapes = 1'b0;
            cfg.strict_mode           = 1'b0;
            st = '0;
            expected_tokens.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                checked++;
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result kind %0d byte %02h last %0b",
                                 $time, i_out.kind, i_out.out_byte, i_out.last);
                    end
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_out.kind !== want.kind || i_out.out_byte !== want.out_byte ||
                        i_out.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: mismatch, expected kind %0d byte %02h last %0b,",
                                      " got kind %0d byte %02h last %0b"},
                                     $time, want.kind, want.out_byte, want.last,
                                     i_out.kind, i_out.out_byte, i_out.last);
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                tokenize_item(i_in.cmd, i_in.in_byte);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dft_pkg::CFG_DELIM_CHAR:    cfg.delim_char            = i_cfg_data;
                    dft_pkg::CFG_QUOTE_CHAR:    cfg.quote_char            = i_cfg_data;
                    dft_pkg::CFG_COLLAPSE:      cfg.collapse_delims       = i_cfg_data[0];
                    dft_pkg::CFG_BACKSLASH:     cfg.backslash_escapes     = i_cfg_data[0];
                    dft_pkg::CFG_DOUBLED_QUOTE: cfg.doubled_quote_escapes = i_cfg_data[0];
                    dft_pkg::CFG_STRICT:        cfg.strict_mode           = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_checked    <= checked;
        o_pending    <= expected_tokens.size();
    end

    initial begin
        mismatches   = 0;
        checked      = 0;
        o_mismatches = 0;
        o_checked    = 0;
        o_pending    = 0;
    end

endmodule

// ----- bench/delimited_field_tokenizer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimited_field_tokenizer_unit_tb
// Drives records of bytes into the field tokenizer under a series of register
// settings: a directed part for quoting, escaping, delimiter runs and early
// record halts, then random records. Both channels stall at random. The
// checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module delimited_field_tokenizer_unit_tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 180;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_idx;
    logic [7:0] cfg_data;
    bit         calm;
    int         mismatches;
    int         pending;
    int         checked;
    int         idle_cycles;
    int         records_sent;
    int         bytes_sent;
    int         settings_used;

    dft_in_if  in_ch();
    dft_out_if out_ch();

    delimited_field_tokenizer_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dft_token_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(negedge clk) begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 13);
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= STALL_LIMIT) begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, pending);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] b);
        if (!calm) begin
            while ($urandom_range(0, 99) < 13) begin
                in_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.in_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        if (cmd) begin
            records_sent++;
        end else begin
            bytes_sent++;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(1'b0, b);
    endtask

    task automatic end_record();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // registers change only once all results are out and the pipe has settled
    task automatic apply_settings(input dft_pkg::t_cfg c);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= dft_pkg::CFG_DELIM_CHAR;    cfg_data <= c.delim_char;
        @(negedge clk);
        cfg_idx <= dft_pkg::CFG_QUOTE_CHAR;    cfg_data <= c.quote_char;
        @(negedge clk);
        cfg_idx <= dft_pkg::CFG_COLLAPSE;      cfg_data <= {7'd0, c.collapse_delims};
        @(negedge clk);
        cfg_idx <= dft_pkg::CFG_BACKSLASH;     cfg_data <= {7'd0, c.backslash_escapes};
        @(negedge clk);
        cfg_idx <= dft_pkg::CFG_DOUBLED_QUOTE; cfg_data <= {7'd0, c.doubled_quote_escapes};
        @(negedge clk);
        cfg_idx <= dft_pkg::CFG_STRICT;        cfg_data <= {7'd0, c.strict_mode};
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    function automatic dft_pkg::t_cfg random_settings();
        dft_pkg::t_cfg c;
        case ($urandom_range(0, 3))
            0: c.delim_char = dft_pkg::DELIM_RESET;
            1: c.delim_char = 8'h00;
            2: c.delim_char = 8'hFF;
            default: c.delim_char = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 5))
            0: c.quote_char = dft_pkg::QUOTE_RESET;
            1: c.quote_char = c.delim_char;
            2: c.quote_char = dft_pkg::BACKSLASH_BYTE;
            3: c.quote_char = 8'hFF;
            4: c.quote_char = 8'h00;
            default: c.quote_char = 8'($urandom_range(0, 255));
        endcase
        c.collapse_delims       = 1'($urandom_range(0, 1));
        c.backslash_escapes     = 1'($urandom_range(0, 1));
        c.doubled_quote_escapes = 1'($urandom_range(0, 1));
        c.strict_mode           = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // mostly the bytes that steer the parser, some text, a few halts
    function automatic logic [7:0] record_byte(input dft_pkg::t_cfg c);
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return c.delim_char;
        if (r < 40) return c.quote_char;
        if (r < 50) return dft_pkg::BACKSLASH_BYTE;
        if (r < 53) return 8'h00;
        if (r < 80) return 8'("a" + $urandom_range(0, 25));
        return 8'($urandom_range(1, 255));
    endfunction

    initial begin
        dft_pkg::t_cfg c;
        int            phase_items;
        int            len;
        int            random_sent;

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = dft_pkg::CFG_DELIM_CHAR;
        cfg_data      = 8'd0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = 1'b0;
        in_ch.in_byte = 8'd0;
        out_ch.ready  = 1'b0;
        calm          = 1'b0;
        idle_cycles   = 0;
        records_sent  = 0;
        bytes_sent    = 0;
        settings_used = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every mode on: delimiter runs, doubled quotes, escapes, strict errors
        apply_settings('{delim_char: 8'd44, quote_char: 8'd34, collapse_delims: 1'b1,
                         backslash_escapes: 1'b1, doubled_quote_escapes: 1'b1,
                         strict_mode: 1'b1});
        send_byte(8'hFF);
        send_byte(",");
        send_byte(",");
        send_byte("\"");
        send_byte("\"");
        send_byte(dft_pkg::BACKSLASH_BYTE);
        send_byte(8'h00);
        send_byte("\"");
        send_byte(",");
        end_record();
        send_byte(dft_pkg::BACKSLASH_BYTE);
        end_record();
        send_byte("b");
        send_byte(8'h00);
        send_byte("c");
        end_record();
        send_byte(",");
        end_record();

        // quote equal to backslash, delimiter at the top of the range
        apply_settings('{delim_char: 8'hFF, quote_char: dft_pkg::BACKSLASH_BYTE,
                         collapse_delims: 1'b0, backslash_escapes: 1'b1,
                         doubled_quote_escapes: 1'b0, strict_mode: 1'b0});
        send_byte(8'hFF);
        send_byte(dft_pkg::BACKSLASH_BYTE);
        send_byte(8'hFF);
        send_byte(dft_pkg::BACKSLASH_BYTE);
        end_record();

        // delimiter and quote both zero
        apply_settings('{delim_char: 8'h00, quote_char: 8'h00, collapse_delims: 1'b1,
                         backslash_escapes: 1'b0, doubled_quote_escapes: 1'b1,
                         strict_mode: 1'b1});
        send_byte(8'h00);
        send_byte(8'h00);
        end_record();

        random_sent = 0;
        for (int phase = 0; phase < 6; phase++) begin
            c = random_settings();
            if (phase == 0) begin
                c.delim_char = 8'd34;
                c.quote_char = 8'd34;
            end
            apply_settings(c);
            calm = (phase == 2);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 6) begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    send_byte(record_byte(c));
                end
                end_record();
                phase_items += len + 1;
            end
            random_sent += phase_items;
        end

        calm = 1'b0;
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);

        $display("covered %0d records, %0d data bytes (%0d random items) over %0d settings",
                 records_sent, bytes_sent, random_sent, settings_used);
        $display("%0d results checked, %0d mismatches", checked, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
